// ----- sv/rlds_pkg.sv -----
package rlds_pkg;

  localparam int VAL_W = 32;
  localparam int SUM_W = 40;
  localparam int CFG_W = 7;
  localparam int ST_W  = 2;
  localparam int PH_W  = 2;
  // width for length compares; holds count plus a short run without wrapping
  localparam int CMP_W = 8;

  localparam int MAX_SAMPLES_DEF = 64;
  localparam logic [CFG_W-1:0] CFG_RST = 7'd64;

  localparam logic [PH_W-1:0] PH_NONE = 2'd0;
  localparam logic [PH_W-1:0] PH_ONE  = 2'd1;
  localparam logic [PH_W-1:0] PH_PAIR = 2'd2;

  localparam logic [ST_W-1:0] ST_SAMPLE   = 2'd0;
  localparam logic [ST_W-1:0] ST_FMT_ERR  = 2'd1;
  localparam logic [ST_W-1:0] ST_DONE_OK  = 2'd2;
  localparam logic [ST_W-1:0] ST_MISMATCH = 2'd3;

  typedef struct packed {
    logic take;
    logic decide;
    logic emit_run;
    logic emit_tail;
    logic emit_err;
    logic emit_stat;
  } rlds_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic plan_run;
    logic plan_tail;
    logic plan_err;
    logic plan_stat;
    logic rem_one;
    logic tail_pend;
  } rlds_stat_t;

endpackage

// ----- sv/rlds_if.sv -----
interface rlds_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [rlds_pkg::VAL_W-1:0]   packed_value;
  logic                                last_packed;

  modport source (output valid, output packed_value, output last_packed, input ready);
  modport sink   (input valid, input packed_value, input last_packed, output ready);
endinterface

interface rlds_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rlds_pkg::SUM_W-1:0]   sample;
  logic                                sample_valid;
  logic [rlds_pkg::ST_W-1:0]           status;
  logic                                run_last;

  modport source (output valid, output sample, output sample_valid, output status,
                  output run_last, input ready);
  modport sink   (input valid, input sample, input sample_valid, input status,
                  input run_last, output ready);
endinterface

interface rlds_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [rlds_pkg::CFG_W-1:0]          expected_samples;

  modport source (output valid, output expected_samples, input ready);
  modport sink   (input valid, input expected_samples, output ready);
endinterface

// ----- sv/rlds_ctrl.sv -----
module rlds_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  rlds_pkg::rlds_stat_t stat,
  output rlds_pkg::rlds_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_RUN    = 3'd2;
  localparam logic [2:0] S_TAIL   = 3'd3;
  localparam logic [2:0] S_ERR    = 3'd4;
  localparam logic [2:0] S_STAT   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.take = 1'b1;
        if (in_valid) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        priority if (stat.plan_err)  state_nxt = S_ERR;
        else if (stat.plan_run)      state_nxt = S_RUN;
        else if (stat.plan_tail)     state_nxt = S_TAIL;
        else if (stat.plan_stat)     state_nxt = S_STAT;
        else                         state_nxt = S_IDLE;
      end
      S_RUN: begin
        if (stat.slot_free) begin
          cmd.emit_run = 1'b1;
          if (stat.rem_one) state_nxt = stat.tail_pend ? S_TAIL : S_IDLE;
        end
      end
      S_TAIL: begin
        if (stat.slot_free) begin
          cmd.emit_tail = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_ERR: begin
        if (stat.slot_free) begin
          cmd.emit_err = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_STAT: begin
        if (stat.slot_free) begin
          cmd.emit_stat = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ----- sv/rlds_dp.sv -----
module rlds_dp #(
  parameter int MAX_SAMPLES = rlds_pkg::MAX_SAMPLES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic signed [rlds_pkg::VAL_W-1:0]   in_value,
  input  logic                                in_last,
  input  logic                                cfg_valid,
  input  logic [rlds_pkg::CFG_W-1:0]          cfg_data,
  output logic                                cfg_ready,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [rlds_pkg::SUM_W-1:0]   out_sample,
  output logic                                out_sample_valid,
  output logic [rlds_pkg::ST_W-1:0]           out_status,
  output logic                                out_run_last,
  input  rlds_pkg::rlds_cmd_t                 cmd,
  output rlds_pkg::rlds_stat_t                stat
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int VW    = rlds_pkg::VAL_W;
  localparam int SW    = rlds_pkg::SUM_W;
  localparam int CW    = rlds_pkg::CMP_W;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_SAMPLES);

  logic [rlds_pkg::CFG_W-1:0] exp_r, exp_nxt;
  logic [VW-1:0]              held_r, held_nxt;
  logic [VW-1:0]              run_val_r, run_val_nxt;
  logic [VW-1:0]              cur_r, cur_nxt;
  logic                       last_r, last_nxt;
  logic [rlds_pkg::PH_W-1:0]  phase_r, phase_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [CNT_W-1:0]           rem_r, rem_nxt;
  logic                       tail_r, tail_nxt;
  logic [SW-1:0]              sum_r, sum_nxt;
  logic                       err_r, err_nxt;
  logic                       ov_r, ov_nxt;
  logic [SW-1:0]              osmp_r, osmp_nxt;
  logic                       osv_r, osv_nxt;
  logic [rlds_pkg::ST_W-1:0]  ost_r, ost_nxt;
  logic                       olast_r, olast_nxt;

  logic [CW-1:0] exp_c, eff_c, cnt_c, cnt_add_c, rep_c;
  logic          room_c, room2_c, rep_bad_c, bad_c, same_c, is_final;
  logic [15:0]   hi_c, lo_c;
  logic [VW-1:0] emit_val;
  logic [SW-1:0] sum_add;

  assign cfg_ready = 1'b1;

  // effective length: zero acts as one, clamp at the top
  always_comb begin
    exp_c = CW'(exp_r);
    if (exp_c == '0)         eff_c = CW'(1);
    else if (exp_c > MAX_C)  eff_c = MAX_C;
    else                     eff_c = exp_c;
  end

  assign cnt_c     = CW'(cnt_r);
  assign cnt_add_c = cnt_c + CW'(1);
  assign room_c    = cnt_c < eff_c;
  assign room2_c   = cnt_add_c < eff_c;
  assign same_c    = cur_r == held_r;

  // run length = integer part (truncated toward zero) plus two
  assign hi_c = cur_r[VW-1:VW-16];
  assign lo_c = cur_r[15:0];
  always_comb begin
    rep_bad_c = 1'b0;
    rep_c     = '0;
    if (!cur_r[VW-1]) begin
      if (hi_c >= 16'd64) rep_bad_c = 1'b1;
      else                rep_c     = CW'(hi_c[5:0]) + CW'(2);
    end else if (hi_c == 16'hFFFF) begin
      rep_c = (lo_c == '0) ? CW'(1) : CW'(2);
    end else if (hi_c == 16'hFFFE && lo_c != '0) begin
      rep_c = CW'(1);
    end else begin
      rep_bad_c = 1'b1;
    end
  end
  assign bad_c = rep_bad_c || ((cnt_c + rep_c) > eff_c);

  // plan for the controller, meaningful while deciding
  always_comb begin
    stat           = '0;
    stat.slot_free = !ov_r || out_ready;
    stat.rem_one   = rem_r == CNT_W'(1);
    stat.tail_pend = tail_r;
    if (!err_r) begin
      unique case (phase_r)
        rlds_pkg::PH_PAIR: begin
          stat.plan_err = bad_c;
          stat.plan_run = !bad_c;
        end
        rlds_pkg::PH_ONE: begin
          if (!room_c)                    stat.plan_stat = last_r;
          else if (!(same_c && !last_r))  stat.plan_run  = 1'b1;
        end
        default: begin
          if (room_c) stat.plan_tail = last_r;
          else        stat.plan_stat = last_r;
        end
      endcase
    end
  end

  assign emit_val = cmd.emit_run ? run_val_r : cur_r;
  assign sum_add  = sum_r + {{(SW-VW){emit_val[VW-1]}}, emit_val};
  assign is_final = cmd.emit_tail || (stat.rem_one && !tail_r);

  always_comb begin
    exp_nxt     = exp_r;
    held_nxt    = held_r;
    run_val_nxt = run_val_r;
    cur_nxt     = cur_r;
    last_nxt    = last_r;
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    rem_nxt     = rem_r;
    tail_nxt    = tail_r;
    sum_nxt     = sum_r;
    err_nxt     = err_r;
    ov_nxt      = ov_r && !out_ready;
    osmp_nxt    = osmp_r;
    osv_nxt     = osv_r;
    ost_nxt     = ost_r;
    olast_nxt   = olast_r;

    if (cfg_valid) exp_nxt = cfg_data;

    if (cmd.take && in_valid) begin
      cur_nxt  = in_value;
      last_nxt = in_last;
    end

    if (cmd.decide) begin
      rem_nxt  = '0;
      tail_nxt = 1'b0;
      if (err_r) begin
        if (last_r) begin
          held_nxt = '0; phase_nxt = rlds_pkg::PH_NONE; cnt_nxt = '0;
          sum_nxt  = '0; err_nxt   = 1'b0;
        end
      end else begin
        unique case (phase_r)
          rlds_pkg::PH_PAIR: begin
            phase_nxt = rlds_pkg::PH_NONE;
            if (bad_c) begin
              if (last_r) begin
                held_nxt = '0; cnt_nxt = '0; sum_nxt = '0;
              end else begin
                err_nxt = 1'b1;
              end
            end else begin
              rem_nxt     = rep_c[CNT_W-1:0];
              run_val_nxt = held_r;
            end
          end
          rlds_pkg::PH_ONE: begin
            if (!room_c) begin
              phase_nxt = rlds_pkg::PH_NONE;
            end else if (same_c && !last_r) begin
              phase_nxt = rlds_pkg::PH_PAIR;
            end else begin
              rem_nxt     = CNT_W'(1);
              run_val_nxt = held_r;
              tail_nxt    = last_r && room2_c;
              if (room2_c && !last_r) held_nxt  = cur_r;
              else                    phase_nxt = rlds_pkg::PH_NONE;
            end
          end
          default: begin
            if (room_c && !last_r) begin
              held_nxt  = cur_r;
              phase_nxt = rlds_pkg::PH_ONE;
            end
          end
        endcase
      end
    end

    if (cmd.emit_run || cmd.emit_tail) begin
      sum_nxt   = sum_add;
      cnt_nxt   = cnt_add_c[CNT_W-1:0];
      if (cmd.emit_run) rem_nxt = rem_r - CNT_W'(1);
      ov_nxt    = 1'b1;
      osmp_nxt  = sum_add;
      osv_nxt   = 1'b1;
      olast_nxt = is_final;
      ost_nxt   = rlds_pkg::ST_SAMPLE;
      if (is_final && last_r) begin
        ost_nxt  = (cnt_add_c == eff_c) ? rlds_pkg::ST_DONE_OK : rlds_pkg::ST_MISMATCH;
        held_nxt = '0; phase_nxt = rlds_pkg::PH_NONE; cnt_nxt = '0;
        sum_nxt  = '0; err_nxt   = 1'b0;
      end
    end

    if (cmd.emit_err) begin
      ov_nxt    = 1'b1;
      osmp_nxt  = '0;
      osv_nxt   = 1'b0;
      ost_nxt   = rlds_pkg::ST_FMT_ERR;
      olast_nxt = 1'b1;
    end

    if (cmd.emit_stat) begin
      ov_nxt    = 1'b1;
      osmp_nxt  = sum_r;
      osv_nxt   = 1'b0;
      ost_nxt   = (cnt_c == eff_c) ? rlds_pkg::ST_DONE_OK : rlds_pkg::ST_MISMATCH;
      olast_nxt = 1'b1;
      held_nxt  = '0; phase_nxt = rlds_pkg::PH_NONE; cnt_nxt = '0;
      sum_nxt   = '0; err_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r   <= rlds_pkg::CFG_RST;
      held_r  <= '0;
      phase_r <= rlds_pkg::PH_NONE;
      cnt_r   <= '0;
      sum_r   <= '0;
      err_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      exp_r   <= exp_nxt;
      held_r  <= held_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      err_r   <= err_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_val_r <= run_val_nxt;
    cur_r     <= cur_nxt;
    last_r    <= last_nxt;
    rem_r     <= rem_nxt;
    tail_r    <= tail_nxt;
    osmp_r    <= osmp_nxt;
    osv_r     <= osv_nxt;
    ost_r     <= ost_nxt;
    olast_r   <= olast_nxt;
  end

  assign out_valid        = ov_r;
  assign out_sample       = osmp_r;
  assign out_sample_valid = osv_r;
  assign out_status       = ost_r;
  assign out_run_last     = olast_r;

endmodule

// ----- sv/rle_derivative_shape_decoder.sv -----
// Channel  | Direction | Carries                                     | Taken when
// ---------+-----------+---------------------------------------------+---------------
// in_chan  | sink      | packed_value (s32 Q16.16), last_packed       | valid & ready
// out_chan | source    | sample (s40 Q24.16), sample_valid, status,   | valid & ready
//          |           | run_last                                     |
// cfg_chan | sink      | expected_samples (u7)                        | valid & ready
//
// Flow: an item is taken in one cycle and decoded in the next, then each result
//   leaves the output register one per cycle while out_chan is not stalled; the
//   input stays held until the item's last result has been issued.
// The sequencing state machine handles one item at a time.
// Reset (rst_n low, synchronous) clears the shape state and sets expected_samples
//   to 64.
// A stall on out_chan holds the result in the output register and freezes the run.
module rle_derivative_shape_decoder #(
  parameter int MAX_SAMPLES = rlds_pkg::MAX_SAMPLES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  rlds_in_if.sink      in_chan,
  rlds_out_if.source   out_chan,
  rlds_cfg_if.sink     cfg_chan
);

  rlds_pkg::rlds_cmd_t  cmd;
  rlds_pkg::rlds_stat_t stat;

  // Controller: take, decode, then walk the run, tail sample, error or status result.
  rlds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: hold the shape state, work out the run length and the length checks,
  // accumulate the running total and own the output register.
  rlds_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_chan.valid),
    .in_value         (in_chan.packed_value),
    .in_last          (in_chan.last_packed),
    .cfg_valid        (cfg_chan.valid),
    .cfg_data         (cfg_chan.expected_samples),
    .cfg_ready        (cfg_chan.ready),
    .out_ready        (out_chan.ready),
    .out_valid        (out_chan.valid),
    .out_sample       (out_chan.sample),
    .out_sample_valid (out_chan.sample_valid),
    .out_status       (out_chan.status),
    .out_run_last     (out_chan.run_last),
    .cmd              (cmd),
    .stat             (stat)
  );

  // Accept only while idle; decode and emission keep the input stalled.
  assign in_chan.ready = cmd.take;

endmodule

// ----- sv/rlds_checker.sv -----
module rlds_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [rlds_pkg::SUM_W-1:0]   out_sample,
  input logic                                out_sample_valid,
  input logic [rlds_pkg::ST_W-1:0]           out_status,
  input logic                                out_run_last
);

  // one item at a time: decode follows acceptance
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again during decode");

  a_status_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != rlds_pkg::ST_SAMPLE |-> out_run_last)
    else $error("status result is not the last of its item");

  a_bare_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_sample_valid |-> out_status != rlds_pkg::ST_SAMPLE)
    else $error("result without sample carries no status");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == rlds_pkg::ST_FMT_ERR |-> !out_sample_valid && out_sample == '0)
    else $error("format error result carries data");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("stalled result changed");

endmodule

bind rle_derivative_shape_decoder rlds_checker u_rlds_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_sample       (out_chan.sample),
  .out_sample_valid (out_chan.sample_valid),
  .out_status       (out_chan.status),
  .out_run_last     (out_chan.run_last)
);
